>>> sv/efvs_pkg.sv
// Package: shared types, constants and fixed-point helpers for the flux splitter.
`timescale 1ns / 1ps

package efvs_pkg;

	localparam int FRAC_W = 20;
	localparam int GAMMA_W = 22;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 22'd1468006;
	localparam logic signed [22:0] ONE_Q = 23'sd1048576;

	// input queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	// latencies of the back-end units, in enabled cycles
	localparam int DIV_LAT = 34;
	localparam int SQRT_LAT = 27;
	localparam int CELL_LAT = 111;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = 32'sh7FFFFFFF;
	localparam q_t Q_MIN = 32'sh80000000;

	typedef struct packed {
		q_t   left_density;
		q_t   left_momentum;
		q_t   left_energy;
		q_t   right_density;
		q_t   right_momentum;
		q_t   right_energy;
		logic left_bad;
		logic right_bad;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} front_t;

	typedef struct packed {
		q_t   mass;
		q_t   momentum;
		q_t   energy;
		logic bad;
	} cell_out_t;

	// Q.20 rounding of a full product: nearest, ties away from zero, then saturate
	function automatic q_t q_round(input logic signed [63:0] prod);
		logic [63:0] mag;
		logic [63:0] sum;
		logic [44:0] r;
		mag = prod[63] ? 64'(-prod) : 64'(prod);
		sum = mag + 64'd524288;
		r = sum[63:19] >> 1;
		if (prod[63]) begin
			if (r > 45'h80000000) return Q_MIN;
			return q_t'(32'(~r[31:0]) + 32'd1);
		end
		if (r > 45'h7FFFFFFF) return Q_MAX;
		return q_t'(r[31:0]);
	endfunction

	// saturate a grown sum to 32 bits
	function automatic q_t q_sat(input logic signed [34:0] v);
		if (v > 35'sd2147483647) return Q_MAX;
		if (v < -35'sd2147483648) return Q_MIN;
		return q_t'(v[31:0]);
	endfunction

	// product with 0.5
	function automatic q_t q_half(input q_t x);
		logic signed [63:0] w;
		w = 64'(x) <<< 19;
		return q_round(w);
	endfunction

	// positive or negative part
	function automatic q_t q_part(input q_t x, input logic pos);
		if (pos) return (x > 32'sd0) ? x : 32'sd0;
		return (x < 32'sd0) ? x : 32'sd0;
	endfunction

endpackage

>>> sv/efvs_intf.sv
// Interfaces: cell-pair input channel, flux output channel and gamma write channel.
`timescale 1ns / 1ps

interface efvs_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_density;
	logic signed [31:0] left_momentum;
	logic signed [31:0] left_energy;
	logic signed [31:0] right_density;
	logic signed [31:0] right_momentum;
	logic signed [31:0] right_energy;

	modport source(output valid, left_density, left_momentum, left_energy,
		right_density, right_momentum, right_energy, input ready);
	modport sink(input valid, left_density, left_momentum, left_energy,
		right_density, right_momentum, right_energy, output ready);
endinterface

interface efvs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mass_flux;
	logic signed [31:0] momentum_flux;
	logic signed [31:0] energy_flux;
	logic               state_invalid;

	modport source(output valid, mass_flux, momentum_flux, energy_flux, state_invalid,
		input ready);
	modport sink(input valid, mass_flux, momentum_flux, energy_flux, state_invalid,
		output ready);
endinterface

interface efvs_cfg_if;
	logic        valid;
	logic        ready;
	logic [21:0] gas_gamma;

	modport source(output valid, gas_gamma, input ready);
	modport sink(input valid, gas_gamma, output ready);
endinterface

>>> sv/euler_flux_vector_split_1d_core.sv
// Top level: Steger-Warming split interface flux for 1D Euler flow.
`timescale 1ns / 1ps

// Takes one interface (left and right conserved cell states, signed Q12.20) per
// clock while results are taken, and returns the split flux F = A+(left) U_left +
// A-(right) U_right with a state_invalid flag. Sustained rate is one transaction per
// cycle while results are taken. The 111-stage cell lanes hold most of the arithmetic:
// two dependent bit-per-stage dividers (velocity, then sound-speed argument and
// enthalpy) and the square-root pipeline, with the multiply and saturate stages
// between them. A four-entry queue separates input acceptance from the arithmetic,
// and the output register holds a result while the queue keeps taking input; when
// the result is not taken the whole arithmetic pipeline holds. The user must write
// gas_gamma (reset 1.4) through cfg only while the block is idle; the block itself
// does not enforce it.
module euler_flux_vector_split_1d_core import efvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	efvs_in_if.sink    cell_pair,
	efvs_out_if.source flux,
	efvs_cfg_if.sink   cfg
);

	logic [GAMMA_W-1:0] gas_gamma_q;
	front_t             head;
	logic               en;
	logic               pop;
	logic               v111;
	cell_out_t          left_out;
	cell_out_t          right_out;
	logic               out_valid_q;
	q_t                 mass_q, mom_q, ener_q;
	logic               invalid_q;
	logic               any_bad;

	// gamma register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gas_gamma_q <= GAMMA_RESET;
		else if (cfg.valid) gas_gamma_q <= cfg.gas_gamma;
	end

	efvs_front u_front (.clk, .arst_n, .src(cell_pair), .head, .pop);

	// pipeline advances unless a finished result is waiting
	assign en  = !out_valid_q || flux.ready;
	assign pop = en && head.valid;

	efvs_cell u_left (
		.clk, .arst_n, .en, .pos_side(1'b1), .gamma(gas_gamma_q),
		.rho(head.item.left_density), .mom(head.item.left_momentum),
		.ener(head.item.left_energy), .rho_bad(head.item.left_bad), .flux(left_out)
	);

	efvs_cell u_right (
		.clk, .arst_n, .en, .pos_side(1'b0), .gamma(gas_gamma_q),
		.rho(head.item.right_density), .mom(head.item.right_momentum),
		.ener(head.item.right_energy), .rho_bad(head.item.right_bad), .flux(right_out)
	);

	efvs_dly #(1, CELL_LAT) d_valid (.clk, .arst_n, .en, .d(head.valid), .q(v111));

	assign any_bad = left_out.bad | right_out.bad;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v111;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mass_q    <= any_bad ? 32'sd0 : q_sat(35'(left_out.mass) + 35'(right_out.mass));
			mom_q     <= any_bad ? 32'sd0 :
				q_sat(35'(left_out.momentum) + 35'(right_out.momentum));
			ener_q    <= any_bad ? 32'sd0 : q_sat(35'(left_out.energy) + 35'(right_out.energy));
			invalid_q <= any_bad;
		end
	end

	assign flux.valid         = out_valid_q;
	assign flux.mass_flux     = mass_q;
	assign flux.momentum_flux = mom_q;
	assign flux.energy_flux   = ener_q;
	assign flux.state_invalid = invalid_q;

endmodule

>>> sv/efvs_dly.sv
// Enabled delay line used to align operands across the back-end pipeline.
`timescale 1ns / 1ps

module efvs_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

>>> sv/efvs_front.sv
// Front end: takes transactions, flags non-positive densities, queues them.
`timescale 1ns / 1ps

module efvs_front import efvs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	efvs_in_if.sink       src,
	output front_t        head,
	input  logic          pop
);

	item_t             mem [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     cnt_q;
	logic              push;
	item_t             item_in;

	// classify: density must be strictly positive
	always_comb begin
		item_in.left_density   = src.left_density;
		item_in.left_momentum  = src.left_momentum;
		item_in.left_energy    = src.left_energy;
		item_in.right_density  = src.right_density;
		item_in.right_momentum = src.right_momentum;
		item_in.right_energy   = src.right_energy;
		item_in.left_bad       = (src.left_density <= 32'sd0);
		item_in.right_bad      = (src.right_density <= 32'sd0);
	end

	assign src.ready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign push      = src.valid && src.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= item_in;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem[rd_ptr_q];

endmodule

>>> sv/efvs_div.sv
// Pipelined Q.20 divider: one quotient bit per stage, rounded and saturated.
`timescale 1ns / 1ps

module efvs_div import efvs_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q_t   num,
	input  q_t   den,
	output q_t   quo
);

	localparam int STEPS = 32;

	logic [31:0] n_mag;
	logic [31:0] d_mag;
	logic [51:0] x_full;

	logic [31:0] rem_s [STEPS+1];
	logic [31:0] quo_s [STEPS+1];
	logic [31:0] low_s [STEPS+1];
	logic [31:0] dm_s  [STEPS+1];
	logic        ovf_s [STEPS+1];
	logic        neg_s [STEPS+1];
	logic        dz_s  [STEPS+1];
	logic        nneg_s[STEPS+1];
	logic        nz_s  [STEPS+1];

	// magnitudes and rounding bias
	always_comb begin
		n_mag  = num[31] ? (32'(~num) + 32'd1) : 32'(num);
		d_mag  = den[31] ? (32'(~den) + 32'd1) : 32'(den);
		x_full = {n_mag, 20'd0} + 52'(d_mag >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 32'(x_full[51:32]);
			low_s[0]  <= x_full[31:0];
			quo_s[0]  <= '0;
			dm_s[0]   <= d_mag;
			ovf_s[0]  <= (32'(x_full[51:32]) >= d_mag);
			neg_s[0]  <= num[31] ^ den[31];
			dz_s[0]   <= (den == 32'sd0);
			nneg_s[0] <= num[31];
			nz_s[0]   <= (num == 32'sd0);
		end
	end

	// restoring steps
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][STEPS-1-k]};
			diff  = trial - {1'b0, dm_s[k]};
			ge    = (trial >= {1'b0, dm_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[31:0] : trial[31:0];
				quo_s[k+1]  <= {quo_s[k][30:0], ge};
				low_s[k+1]  <= low_s[k];
				dm_s[k+1]   <= dm_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				neg_s[k+1]  <= neg_s[k];
				dz_s[k+1]   <= dz_s[k];
				nneg_s[k+1] <= nneg_s[k];
				nz_s[k+1]   <= nz_s[k];
			end
		end
	end

	// sign, saturation and zero divisor
	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[STEPS]) begin
				quo <= nneg_s[STEPS] ? Q_MIN : (nz_s[STEPS] ? 32'sd0 : Q_MAX);
			end else if (neg_s[STEPS]) begin
				quo <= (ovf_s[STEPS] || quo_s[STEPS] > 32'h80000000) ? Q_MIN :
					q_t'(~quo_s[STEPS] + 32'd1);
			end else begin
				quo <= (ovf_s[STEPS] || quo_s[STEPS][31]) ? Q_MAX : q_t'(quo_s[STEPS]);
			end
		end
	end

endmodule

>>> sv/efvs_sqrt.sv
// Pipelined integer square root of t * 2^20, one result bit per stage.
`timescale 1ns / 1ps

module efvs_sqrt import efvs_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q_t   val,
	output q_t   root
);

	localparam int STEPS = 26;

	logic [51:0] x_in;
	logic [51:0] x_s    [STEPS+1];
	logic [29:0] rem_s  [STEPS+1];
	logic [25:0] root_s [STEPS+1];

	// negative argument clamps to zero
	assign x_in = {1'b0, (val[31] ? 31'd0 : val[30:0]), 20'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x_in;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [29:0] rem_n;
		logic [29:0] trial;
		logic        ge;

		always_comb begin
			rem_n = {rem_s[k][27:0], x_s[k][2*(STEPS-1-k)+1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = (rem_n >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= x_s[k];
				rem_s[k+1]  <= ge ? (rem_n - trial) : rem_n;
				root_s[k+1] <= {root_s[k][24:0], ge};
			end
		end
	end

	assign root = q_t'({6'd0, root_s[STEPS]});

endmodule

>>> sv/efvs_cell.sv
// Back-end lane: split flux of one cell, positive or negative eigenvalue parts.
`timescale 1ns / 1ps

module efvs_cell import efvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               pos_side,
	input  logic [GAMMA_W-1:0] gamma,
	input  q_t                 rho,
	input  q_t                 mom,
	input  q_t                 ener,
	input  logic               rho_bad,
	output cell_out_t          flux
);

	q_t                 gs;
	logic signed [22:0] g1;

	q_t u, r, t, h, a;
	q_t m34, e37, e40, rho42, u103, u105, a105, rho104, m104, e104, r105, h105, r108;
	q_t lmm110, le110, q1_107, f0_111;
	logic rb40, bad111;

	logic signed [63:0] mu_p, p_p, gp_p, au_p, q1_p, lmm_p, le_p;
	logic signed [63:0] q2_p, ulc_p, alt_p, hlc_p, aut_p, rs1_p, rs2_p;
	q_t mu_s36, ke_s37, es_s38, p_s40, gp_s42, ep_s41, ep_s42;
	logic bad_s41;
	q_t upa_s104, uma_s104, l_s104, lt_s105, lc_s105, au_s105;
	q_t q1_s106, lmm_s106, le_s106, q2_s107, ulc_s107, alt_s107, hlc_s107, aut_s107;
	q_t s1_s108, s2_s108, f0_s108, rs1_s110, rs2_s110, f1_s111, f2_s111;

	assign gs = q_t'({10'd0, gamma});
	assign g1 = $signed({1'b0, gamma}) - ONE_Q;

	// dividers and square root
	efvs_div u_div_u (.clk, .en, .num(mom),    .den(rho),   .quo(u));
	efvs_div u_div_r (.clk, .en, .num(rho),    .den(gs),    .quo(r));
	efvs_div u_div_t (.clk, .en, .num(gp_s42), .den(rho42), .quo(t));
	efvs_div u_div_h (.clk, .en, .num(ep_s42), .den(rho42), .quo(h));
	efvs_sqrt u_sqrt (.clk, .en, .val(t), .root(a));

	// operand alignment
	efvs_dly #(32, 34) d_m34   (.clk, .arst_n, .en, .d(mom),   .q(m34));
	efvs_dly #(32, 37) d_e37   (.clk, .arst_n, .en, .d(ener),  .q(e37));
	efvs_dly #(32, 3)  d_e40   (.clk, .arst_n, .en, .d(e37),   .q(e40));
	efvs_dly #(32, 42) d_rho42 (.clk, .arst_n, .en, .d(rho),   .q(rho42));
	efvs_dly #(1, 40)  d_rb40  (.clk, .arst_n, .en, .d(rho_bad), .q(rb40));
	efvs_dly #(32, 69) d_u103  (.clk, .arst_n, .en, .d(u),     .q(u103));
	efvs_dly #(32, 2)  d_u105  (.clk, .arst_n, .en, .d(u103),  .q(u105));
	efvs_dly #(32, 2)  d_a105  (.clk, .arst_n, .en, .d(a),     .q(a105));
	efvs_dly #(32, 62) d_rho104(.clk, .arst_n, .en, .d(rho42), .q(rho104));
	efvs_dly #(32, 70) d_m104  (.clk, .arst_n, .en, .d(m34),   .q(m104));
	efvs_dly #(32, 64) d_e104  (.clk, .arst_n, .en, .d(e40),   .q(e104));
	efvs_dly #(32, 71) d_r105  (.clk, .arst_n, .en, .d(r),     .q(r105));
	efvs_dly #(32, 29) d_h105  (.clk, .arst_n, .en, .d(h),     .q(h105));
	efvs_dly #(32, 3)  d_r108  (.clk, .arst_n, .en, .d(r105),  .q(r108));
	efvs_dly #(1, 70)  d_bad   (.clk, .arst_n, .en, .d(bad_s41), .q(bad111));
	efvs_dly #(32, 4)  d_lmm   (.clk, .arst_n, .en, .d(lmm_s106), .q(lmm110));
	efvs_dly #(32, 4)  d_le    (.clk, .arst_n, .en, .d(le_s106),  .q(le110));
	efvs_dly #(32, 1)  d_q1    (.clk, .arst_n, .en, .d(q1_s106),  .q(q1_107));
	efvs_dly #(32, 3)  d_f0    (.clk, .arst_n, .en, .d(f0_s108),  .q(f0_111));

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (en) begin
			// kinetic energy and pressure
			mu_p   <= m34 * u;
			mu_s36 <= q_round(mu_p);
			ke_s37 <= q_half(mu_s36);
			es_s38 <= q_sat(35'(e37) - 35'(ke_s37));
			p_p    <= 64'(g1) * 64'(es_s38);
			p_s40  <= q_round(p_p);
			bad_s41 <= rb40 | (p_s40 <= 32'sd0);
			gp_p   <= gs * p_s40;
			gp_s42 <= q_round(gp_p);
			ep_s41 <= q_sat(35'(e40) + 35'(p_s40));
			ep_s42 <= ep_s41;

			// eigenvalue parts
			upa_s104 <= q_part(q_sat(35'(u103) + 35'(a)), pos_side);
			uma_s104 <= q_part(q_sat(35'(u103) - 35'(a)), pos_side);
			l_s104   <= q_part(u103, pos_side);
			lt_s105  <= q_half(q_sat(35'(upa_s104) - 35'(uma_s104)));
			lc_s105  <= q_half(q_sat(35'(upa_s104) + 35'(uma_s104) - (35'(l_s104) <<< 1)));
			au_p     <= a * u103;
			au_s105  <= q_round(au_p);

			// diagonal terms
			q1_p     <= l_s104 * rho104;
			q1_s106  <= q_round(q1_p);
			lmm_p    <= l_s104 * m104;
			lmm_s106 <= q_round(lmm_p);
			le_p     <= l_s104 * e104;
			le_s106  <= q_round(le_p);

			// outer-product terms
			q2_p     <= r105 * lc_s105;
			q2_s107  <= q_round(q2_p);
			ulc_p    <= u105 * lc_s105;
			ulc_s107 <= q_round(ulc_p);
			alt_p    <= a105 * lt_s105;
			alt_s107 <= q_round(alt_p);
			hlc_p    <= h105 * lc_s105;
			hlc_s107 <= q_round(hlc_p);
			aut_p    <= au_s105 * lt_s105;
			aut_s107 <= q_round(aut_p);

			s1_s108  <= q_sat(35'(ulc_s107) + 35'(alt_s107));
			s2_s108  <= q_sat(35'(hlc_s107) + 35'(aut_s107));
			f0_s108  <= q_sat(35'(q1_107) + 35'(q2_s107));
			rs1_p    <= r108 * s1_s108;
			rs1_s110 <= q_round(rs1_p);
			rs2_p    <= r108 * s2_s108;
			rs2_s110 <= q_round(rs2_p);
			f1_s111  <= q_sat(35'(lmm110) + 35'(rs1_s110));
			f2_s111  <= q_sat(35'(le110) + 35'(rs2_s110));
		end
	end

	assign flux.mass     = f0_111;
	assign flux.momentum = f1_s111;
	assign flux.energy   = f2_s111;
	assign flux.bad      = bad111;

endmodule
